@@ hw/rtl/frr_pkg.sv @@
// Package with the shared types and constants of the fixed bit range rounding block.
`timescale 1ns / 1ps

package frr_pkg;

    // Width of every field and configuration register on the ports.
    localparam int FIELD_W       = 32;
    localparam int DEFAULT_WIDTH = 32;
    localparam int ACTION_W      = 2;
    localparam int CFG_IDX_W     = 2;

    // Action codes; the unused code behaves as a check.
    localparam logic [ACTION_W-1:0] ACT_CHECK    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_AT_LEAST = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_AT_MOST  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FIXED_MASK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIXED_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH = 2'd3;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [FIELD_W-1:0]  value_in;
    } t_in_item;

    typedef struct packed {
        logic [FIELD_W-1:0] value_out;
        logic               ok;
    } t_out_item;

    typedef struct packed {
        logic [FIELD_W-1:0] fixed_mask;
        logic [FIELD_W-1:0] fixed_bits;
        logic [FIELD_W-1:0] range_low;
        logic [FIELD_W-1:0] range_high;
    } t_cfg;

    // Control that travels with an item down the pipeline.
    typedef struct packed {
        logic                valid;
        logic [ACTION_W-1:0] action;
    } t_ctl;

endpackage

@@ hw/rtl/frr_cfg.sv @@
// Configuration register file of the fixed bit range rounding block.
`timescale 1ns / 1ps

module frr_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_we,
    input  logic [frr_pkg::CFG_IDX_W-1:0]   i_index,
    input  logic [frr_pkg::FIELD_W-1:0]     i_data,
    output frr_pkg::t_cfg                   o_cfg
);

    frr_pkg::t_cfg r_cfg;
    frr_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_we) begin
            case (i_index)
                frr_pkg::CFG_FIXED_MASK: n_cfg.fixed_mask = i_data;
                frr_pkg::CFG_FIXED_BITS: n_cfg.fixed_bits = i_data;
                frr_pkg::CFG_RANGE_LOW:  n_cfg.range_low  = i_data;
                frr_pkg::CFG_RANGE_HIGH: n_cfg.range_high = i_data;
                default:                 n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ hw/rtl/frr_locate.sv @@
// First stage: finds the highest disagreeing fixed bit as a thermometer and a one-hot mask.
`timescale 1ns / 1ps

module frr_locate #(
    parameter int WIDTH = frr_pkg::DEFAULT_WIDTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  frr_pkg::t_in_item i_item,
    input  frr_pkg::t_cfg     i_cfg,
    output frr_pkg::t_ctl     o_ctl,
    output logic [WIDTH-1:0]  o_value,
    output logic [WIDTH-1:0]  o_le,
    output logic [WIDTH-1:0]  o_dh
);

    logic [WIDTH-1:0] value_w;
    logic [WIDTH-1:0] diff;
    logic [WIDTH-1:0] n_le;
    logic [WIDTH-1:0] n_dh;
    frr_pkg::t_ctl    n_ctl;

    frr_pkg::t_ctl    r_ctl;
    logic [WIDTH-1:0] r_value;
    logic [WIDTH-1:0] r_le;
    logic [WIDTH-1:0] r_dh;

    assign value_w = WIDTH'(i_item.value_in);
    assign diff    = (value_w ^ WIDTH'(i_cfg.fixed_bits)) & WIDTH'(i_cfg.fixed_mask);

    // A position lies at or below the top disagreement when some difference sits at or above it.
    always_comb begin
        for (int i = 0; i < WIDTH; i++) begin
            n_le[i] = |(diff >> i);
        end
        n_dh = n_le & ~(n_le >> 1);
    end

    assign n_ctl.valid  = i_valid;
    assign n_ctl.action = i_item.action;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_value <= value_w;
            r_le    <= n_le;
            r_dh    <= n_dh;
        end
    end

    assign o_ctl   = r_ctl;
    assign o_value = r_value;
    assign o_le    = r_le;
    assign o_dh    = r_dh;

endmodule

@@ hw/rtl/frr_round.sv @@
// Second stage: raises or lowers the value so that its fixed bits agree.
`timescale 1ns / 1ps

module frr_round #(
    parameter int WIDTH = frr_pkg::DEFAULT_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  frr_pkg::t_ctl    i_ctl,
    input  logic [WIDTH-1:0] i_value,
    input  logic [WIDTH-1:0] i_le,
    input  logic [WIDTH-1:0] i_dh,
    input  frr_pkg::t_cfg    i_cfg,
    output frr_pkg::t_ctl    o_ctl,
    output logic [WIDTH-1:0] o_x
);

    logic [WIDTH-1:0] fm;
    logic [WIDTH-1:0] fixed_low;
    logic [WIDTH-1:0] free_up;
    logic [WIDTH-1:0] base_r;
    logic [WIDTH-1:0] base_l;
    logic [WIDTH-1:0] cand_r;
    logic [WIDTH-1:0] cand_l;
    logic [WIDTH-1:0] pick_r;
    logic [WIDTH-1:0] pick_l;
    logic [WIDTH-1:0] raised;
    logic [WIDTH-1:0] lowered;
    logic             has_diff;
    logic [WIDTH-1:0] n_x;

    frr_pkg::t_ctl    r_ctl;
    logic [WIDTH-1:0] r_x;

    assign fm        = WIDTH'(i_cfg.fixed_mask);
    assign fixed_low = WIDTH'(i_cfg.fixed_bits) & fm & i_le;
    assign free_up   = ~fm & ~i_le;
    assign has_diff  = |i_le;

    // Free positions up to the top disagreement go to zero when raising and to one when lowering.
    assign base_r = (i_value & ~i_le) | fixed_low;
    assign base_l = (i_value & ~i_le) | fixed_low | (~fm & i_le);

    assign cand_r = free_up & ~base_r;
    assign cand_l = free_up & base_l;
    assign pick_r = cand_r & (~cand_r + WIDTH'(1));
    assign pick_l = cand_l & (~cand_l + WIDTH'(1));

    always_comb begin
        if (!has_diff) begin
            raised = i_value;
        end else if (|(base_r & i_dh)) begin
            raised = base_r;
        end else if (|cand_r) begin
            raised = base_r | pick_r;
        end else begin
            raised = base_r & fm;
        end

        if (!has_diff) begin
            lowered = i_value;
        end else if (!(|(base_l & i_dh))) begin
            lowered = base_l;
        end else if (|cand_l) begin
            lowered = base_l & ~pick_l;
        end else begin
            lowered = base_l | free_up;
        end

        case (i_ctl.action)
            frr_pkg::ACT_AT_LEAST: n_x = raised;
            frr_pkg::ACT_AT_MOST:  n_x = lowered;
            default:               n_x = i_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
        end
    end

    assign o_ctl = r_ctl;
    assign o_x   = r_x;

endmodule

@@ hw/rtl/frr_select.sv @@
// Third stage: checks feasibility, applies the fallbacks and holds the output register.
`timescale 1ns / 1ps

module frr_select #(
    parameter int WIDTH = frr_pkg::DEFAULT_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  frr_pkg::t_ctl      i_ctl,
    input  logic [WIDTH-1:0]   i_x,
    input  frr_pkg::t_cfg      i_cfg,
    output logic               o_valid,
    output frr_pkg::t_out_item o_item
);

    logic [WIDTH-1:0]   fm;
    logic [WIDTH-1:0]   lo;
    logic [WIDTH-1:0]   hi;
    logic               fix_ok;
    logic               in_span;
    logic               feas;
    logic [WIDTH-1:0]   res;
    logic               ok;
    frr_pkg::t_out_item n_item;

    logic               r_valid;
    frr_pkg::t_out_item r_item;

    assign fm = WIDTH'(i_cfg.fixed_mask);
    assign lo = WIDTH'(i_cfg.range_low);
    assign hi = WIDTH'(i_cfg.range_high);

    assign fix_ok = ((i_x ^ WIDTH'(i_cfg.fixed_bits)) & fm) == '0;

    // The interval wraps round when its start lies above its end.
    always_comb begin
        if (lo == hi) begin
            in_span = 1'b1;
        end else if (lo < hi) begin
            in_span = (lo <= i_x) && (i_x < hi);
        end else begin
            in_span = (lo <= i_x) || (i_x < hi);
        end
    end

    assign feas = fix_ok && in_span;

    always_comb begin
        res = '0;
        ok  = 1'b0;
        case (i_ctl.action)
            frr_pkg::ACT_AT_LEAST: begin
                if (feas) begin
                    res = i_x;
                    ok  = 1'b1;
                end else if (!(i_x > lo)) begin
                    res = lo;
                    ok  = 1'b1;
                end
            end
            frr_pkg::ACT_AT_MOST: begin
                if (feas) begin
                    res = i_x;
                    ok  = 1'b1;
                end else if (!(((i_x < lo) && (lo < hi)) || (hi == '0))) begin
                    res = hi - WIDTH'(1);
                    ok  = 1'b1;
                end
            end
            default: begin
                res = i_x;
                ok  = feas;
            end
        endcase
        n_item.value_out = frr_pkg::FIELD_W'(res);
        n_item.ok        = ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

@@ hw/rtl/fixed_bit_range_rounding.sv @@
// Top level of the fixed bit range rounding block.
//
//  Channel   Direction  Handshake                    Payload
//  in        sink       i_in_valid / o_in_stall      i_in_item  (action, value_in)
//  out       source     o_out_valid / i_out_stall    o_out_item (value_out, ok)
//  cfg       sink       i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// One item is taken every cycle while the output does not stall; each result is registered in
// the locator, the rounding stage and the output register before it is on the outputs.
// The three stages are the disagreement locator, the rounding logic and the feasibility
// check with its output register. Reset clears the valid bits and the four registers.
// A stage that is empty or moving on takes a new item, so bubbles close up under a stall.
`timescale 1ns / 1ps

module fixed_bit_range_rounding #(
    parameter int WIDTH = frr_pkg::DEFAULT_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  frr_pkg::t_in_item             i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output frr_pkg::t_out_item            o_out_item,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [frr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [frr_pkg::FIELD_W-1:0]   i_cfg_data
);

    frr_pkg::t_cfg    cfg;
    frr_pkg::t_ctl    ctl1;
    frr_pkg::t_ctl    ctl2;
    logic [WIDTH-1:0] value1;
    logic [WIDTH-1:0] le1;
    logic [WIDTH-1:0] dh1;
    logic [WIDTH-1:0] x2;
    logic             rdy1;
    logic             rdy2;
    logic             rdy3;

    assign o_cfg_ready = 1'b1;

    assign rdy3       = !o_out_valid || !i_out_stall;
    assign rdy2       = !ctl2.valid || rdy3;
    assign rdy1       = !ctl1.valid || rdy2;
    assign o_in_stall = !rdy1;

    frr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    frr_locate #(.WIDTH(WIDTH)) u_locate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (rdy1),
        .i_valid (i_in_valid),
        .i_item  (i_in_item),
        .i_cfg   (cfg),
        .o_ctl   (ctl1),
        .o_value (value1),
        .o_le    (le1),
        .o_dh    (dh1)
    );

    frr_round #(.WIDTH(WIDTH)) u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (rdy2),
        .i_ctl   (ctl1),
        .i_value (value1),
        .i_le    (le1),
        .i_dh    (dh1),
        .i_cfg   (cfg),
        .o_ctl   (ctl2),
        .o_x     (x2)
    );

    frr_select #(.WIDTH(WIDTH)) u_select (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (rdy3),
        .i_ctl   (ctl2),
        .i_x     (x2),
        .i_cfg   (cfg),
        .o_valid (o_out_valid),
        .o_item  (o_out_item)
    );

endmodule

@@ hw/rtl/frr_checker.sv @@
// Port-level checker of the fixed bit range rounding block and its bind statement.
`timescale 1ns / 1ps

module frr_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input frr_pkg::t_out_item o_out_item
);

    logic in_acc;

    assign in_acc = i_in_valid && !o_in_stall;

    // The pipeline comes out of reset empty.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid straight after reset");

    // A held result keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed or vanished");

    // Items are refused only while a result is held at a full output.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a held result");

    // With the output flowing, a taken item reaches the output.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc ##1 !i_out_stall ##1 !i_out_stall |=> o_out_valid)
        else $error("item did not reach the output in time");

endmodule

bind fixed_bit_range_rounding frr_checker u_frr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

@@ sim/testbench.sv @@
// Self-checking testbench for the fixed bit range rounding block.
`timescale 1ns / 1ps

module testbench;

    localparam logic [frr_pkg::ACTION_W-1:0] ACT_SPARE = 2'd3;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_QUERIES = 48;
    localparam int LONG_HOLD = 80;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    frr_pkg::t_in_item i_in_item = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    frr_pkg::t_out_item o_out_item;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [frr_pkg::CFG_IDX_W-1:0] i_cfg_index = frr_pkg::CFG_FIXED_MASK;
    logic [frr_pkg::FIELD_W-1:0] i_cfg_data = '0;

    // Shadow copy of the four registers, as the block should hold them.
    logic [frr_pkg::FIELD_W-1:0] reg_mask = '0;
    logic [frr_pkg::FIELD_W-1:0] reg_bits = '0;
    logic [frr_pkg::FIELD_W-1:0] reg_lo = '0;
    logic [frr_pkg::FIELD_W-1:0] reg_hi = '0;

    frr_pkg::t_in_item pending_queries[$];
    frr_pkg::t_out_item expected_roundings[$];

    int queries_taken = 0;
    int results_checked = 0;
    int failures = 0;
    int settings_used = 0;
    int burst_left = 0;
    int gap_left = 0;
    bit dense_sender = 1'b0;
    int stall_mode = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int cycle_count = 0;
    frr_pkg::t_out_item want;

    fixed_bit_range_rounding dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in_item(i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item(o_out_item),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic in_window(logic [frr_pkg::FIELD_W-1:0] v);
        if (reg_lo == reg_hi) return 1'b1;
        if (reg_lo < reg_hi) return (v >= reg_lo) && (v < reg_hi);
        return (v >= reg_lo) || (v < reg_hi);
    endfunction

    function automatic logic admissible(logic [frr_pkg::FIELD_W-1:0] v);
        return (((v ^ reg_bits) & reg_mask) == '0) && in_window(v);
    endfunction

    // Highest fixed position where v disagrees, or -1 when it agrees everywhere.
    function automatic int top_conflict(logic [frr_pkg::FIELD_W-1:0] v);
        logic [frr_pkg::FIELD_W-1:0] diff;
        int i;
        diff = (v ^ reg_bits) & reg_mask;
        for (i = frr_pkg::FIELD_W - 1; i >= 0; i--)
            if (diff[i]) return i;
        return -1;
    endfunction

    function automatic logic [frr_pkg::FIELD_W-1:0] raise_to_fixed(
        logic [frr_pkg::FIELD_W-1:0] v);
        int d;
        int i;
        d = top_conflict(v);
        if (d < 0) return v;
        for (i = 0; i <= d; i++)
            v[i] = reg_mask[i] ? reg_bits[i] : 1'b0;
        if (v[d]) return v;
        for (i = d + 1; i < frr_pkg::FIELD_W; i++) begin
            if (!reg_mask[i] && !v[i]) begin
                v[i] = 1'b1;
                return v;
            end
        end
        return v & reg_mask;
    endfunction

    function automatic logic [frr_pkg::FIELD_W-1:0] lower_to_fixed(
        logic [frr_pkg::FIELD_W-1:0] v);
        int d;
        int i;
        d = top_conflict(v);
        if (d < 0) return v;
        for (i = 0; i <= d; i++)
            v[i] = reg_mask[i] ? reg_bits[i] : 1'b1;
        if (!v[d]) return v;
        for (i = d + 1; i < frr_pkg::FIELD_W; i++) begin
            if (!reg_mask[i] && v[i]) begin
                v[i] = 1'b0;
                return v;
            end
        end
        for (i = d + 1; i < frr_pkg::FIELD_W; i++)
            if (!reg_mask[i]) v[i] = 1'b1;
        return v;
    endfunction

    function automatic frr_pkg::t_out_item round_query(frr_pkg::t_in_item q);
        frr_pkg::t_out_item r;
        logic [frr_pkg::FIELD_W-1:0] cand;
        r.value_out = '0;
        r.ok = 1'b0;
        case (q.action)
            frr_pkg::ACT_AT_LEAST: begin
                cand = raise_to_fixed(q.value_in);
                if (admissible(cand)) begin
                    r.value_out = cand;
                    r.ok = 1'b1;
                end else if (!(cand > reg_lo)) begin
                    r.value_out = reg_lo;
                    r.ok = 1'b1;
                end
            end
            frr_pkg::ACT_AT_MOST: begin
                cand = lower_to_fixed(q.value_in);
                if (admissible(cand)) begin
                    r.value_out = cand;
                    r.ok = 1'b1;
                end else if (!((cand < reg_lo && reg_lo < reg_hi) || reg_hi == '0)) begin
                    r.value_out = reg_hi - 1'b1;
                    r.ok = 1'b1;
                end
            end
            default: begin
                // The spare action code is treated as a plain check.
                r.value_out = q.value_in;
                r.ok = admissible(q.value_in);
            end
        endcase
        return r;
    endfunction

    function automatic frr_pkg::t_in_item make_query(logic [frr_pkg::ACTION_W-1:0] act,
                                                     logic [frr_pkg::FIELD_W-1:0] v);
        frr_pkg::t_in_item q;
        q.action = act;
        q.value_in = v;
        return q;
    endfunction

    // Sender: bursts of random length, separated by random gaps unless running dense.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                expected_roundings.push_back(round_query(i_in_item));
                queries_taken++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_queries.size() > 0) begin
                    i_in_item <= pending_queries.pop_front();
                    i_in_valid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 16);
                        if (!dense_sender) gap_left = $urandom_range(1, 6);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each accepted result and drives its own stall pattern.
    always @(posedge i_clk) begin
        cycle_count++;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                results_checked++;
                if (expected_roundings.size() == 0) begin
                    $error("result with nothing expected: value_out %h ok %b",
                           o_out_item.value_out, o_out_item.ok);
                    failures++;
                end else begin
                    want = expected_roundings.pop_front();
                    if (o_out_item.value_out !== want.value_out) begin
                        $error("value_out: expected %h, got %h",
                               want.value_out, o_out_item.value_out);
                        failures++;
                    end
                    if (o_out_item.ok !== want.ok) begin
                        $error("ok: expected %b, got %b", want.ok, o_out_item.ok);
                        failures++;
                    end
                end
            end
            if (hold_served != hold_requests) begin
                hold_served++;
                hold_left = LONG_HOLD;
                i_out_stall <= 1'b1;
            end else if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                case (stall_mode)
                    1: i_out_stall <= ($urandom_range(0, 9) < 3);
                    2: i_out_stall <= ((cycle_count % 7) < 3);
                    3: i_out_stall <= ($urandom_range(0, 9) < 7);
                    default: i_out_stall <= 1'b0;
                endcase
            end
        end
    end

    // Called right after a rising edge; leaves the write valid high for the next register.
    task automatic put_reg(input logic [frr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [frr_pkg::FIELD_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            frr_pkg::CFG_FIXED_MASK: reg_mask = data;
            frr_pkg::CFG_FIXED_BITS: reg_bits = data;
            frr_pkg::CFG_RANGE_LOW: reg_lo = data;
            default: reg_hi = data;
        endcase
    endtask

    task automatic set_config(input logic [frr_pkg::FIELD_W-1:0] mask,
                              input logic [frr_pkg::FIELD_W-1:0] bits,
                              input logic [frr_pkg::FIELD_W-1:0] lo,
                              input logic [frr_pkg::FIELD_W-1:0] hi);
        put_reg(frr_pkg::CFG_FIXED_MASK, mask);
        put_reg(frr_pkg::CFG_FIXED_BITS, bits);
        put_reg(frr_pkg::CFG_RANGE_LOW, lo);
        put_reg(frr_pkg::CFG_RANGE_HIGH, hi);
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Waits until every item has gone in and every result has come back, then a little more.
    task automatic drain();
        while (pending_queries.size() != 0 || i_in_valid || expected_roundings.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [frr_pkg::FIELD_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0: return ($urandom() & ~reg_mask) | (reg_bits & reg_mask);
            1: return reg_lo + $urandom_range(0, 4) - 32'd2;
            2: return reg_hi + $urandom_range(0, 4) - 32'd2;
            3: return $urandom() | $urandom();
            4: return $urandom() & $urandom();
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [frr_pkg::ACTION_W-1:0] pick_action();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2) return frr_pkg::ACT_CHECK;
        if (r < 6) return frr_pkg::ACT_AT_LEAST;
        if (r < 9) return frr_pkg::ACT_AT_MOST;
        return ACT_SPARE;
    endfunction

    initial begin
        logic [frr_pkg::FIELD_W-1:0] mask, lo, hi, a, b;
        int phase, n, kind;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: no fixed bits and the full range.
        settings_used = 1;
        pending_queries.push_back(make_query(frr_pkg::ACT_CHECK, 32'h0000_0000));
        pending_queries.push_back(make_query(frr_pkg::ACT_CHECK, 32'hFFFF_FFFF));
        pending_queries.push_back(make_query(frr_pkg::ACT_AT_LEAST, 32'h1234_5678));
        pending_queries.push_back(make_query(frr_pkg::ACT_AT_MOST, 32'h0000_0000));
        pending_queries.push_back(make_query(ACT_SPARE, 32'hFFFF_FFFF));
        drain();

        // Ordinary interval with a mix of fixed and free bits.
        set_config(32'hFF00_0F0F, 32'hA500_0503, 32'h2000_0000, 32'hC000_0000);
        pending_queries.push_back(make_query(frr_pkg::ACT_CHECK, 32'hA512_3543));
        pending_queries.push_back(make_query(frr_pkg::ACT_CHECK, 32'h1234_5678));
        pending_queries.push_back(make_query(frr_pkg::ACT_AT_LEAST, 32'h0000_0000));
        pending_queries.push_back(make_query(frr_pkg::ACT_AT_LEAST, 32'hFFFF_FFFF));
        pending_queries.push_back(make_query(frr_pkg::ACT_AT_LEAST, 32'hA512_3543));
        pending_queries.push_back(make_query(frr_pkg::ACT_AT_LEAST, 32'hA600_0000));
        pending_queries.push_back(make_query(frr_pkg::ACT_AT_MOST, 32'h0000_0000));
        pending_queries.push_back(make_query(frr_pkg::ACT_AT_MOST, 32'hFFFF_FFFF));
        pending_queries.push_back(make_query(frr_pkg::ACT_AT_MOST, 32'h1234_5678));
        drain();

        // Interval that wraps past the top of the range.
        set_config(32'h8000_0001, 32'h0000_0001, 32'hF000_0000, 32'h1000_0000);
        pending_queries.push_back(make_query(frr_pkg::ACT_AT_LEAST, 32'h8000_0000));
        pending_queries.push_back(make_query(frr_pkg::ACT_AT_MOST, 32'h7FFF_FFFF));
        pending_queries.push_back(make_query(frr_pkg::ACT_CHECK, 32'h0000_0001));
        pending_queries.push_back(make_query(frr_pkg::ACT_CHECK, 32'hF000_0001));
        pending_queries.push_back(make_query(frr_pkg::ACT_AT_MOST, 32'h0000_0000));
        drain();

        // Every bit fixed, below the start, with the end at zero: round down must fail.
        set_config(32'hFFFF_FFFF, 32'h1234_5678, 32'h2000_0000, 32'h0000_0000);
        pending_queries.push_back(make_query(frr_pkg::ACT_AT_MOST, 32'h0000_0000));
        pending_queries.push_back(make_query(frr_pkg::ACT_AT_LEAST, 32'hFFFF_FFFF));
        pending_queries.push_back(make_query(frr_pkg::ACT_CHECK, 32'h1234_5678));
        drain();

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            // The first five phases walk through every kind of mask and interval once.
            kind = (phase < 5) ? (phase + 2) % 5 : $urandom_range(0, 4);
            case (kind)
                0: mask = 32'h0000_0000;
                1: mask = 32'hFFFF_FFFF;
                2: mask = $urandom() & $urandom();
                3: mask = $urandom() | $urandom();
                default: mask = $urandom();
            endcase
            kind = (phase < 5) ? phase : $urandom_range(0, 4);
            a = $urandom();
            b = $urandom();
            case (kind)
                0: begin lo = a; hi = a; end
                1: begin lo = (a < b) ? a : b; hi = (a < b) ? b : a; end
                2: begin lo = (a < b) ? b : a; hi = (a < b) ? a : b; end
                3: begin lo = 32'h0000_0000; hi = 32'hFFFF_FFFF; end
                default: begin lo = 32'hFFFF_FFFF; hi = 32'h0000_0000; end
            endcase
            set_config(mask, $urandom(), lo, hi);
            stall_mode = phase % 4;
            dense_sender = (phase % 3 == 0);
            for (n = 0; n < PHASE_QUERIES; n++)
                pending_queries.push_back(make_query(pick_action(), pick_value()));
            // A long hold on the result side so the pipeline backs up into the input.
            if (phase == 2 || phase == 5) hold_requests++;
            drain();
        end

        stall_mode = 0;
        repeat (8) @(posedge i_clk);
        $display("%0d items under %0d register settings, %0d results checked, %0d failures",
                 queries_taken, settings_used, results_checked, failures);
        if (failures == 0 && expected_roundings.size() == 0) begin
            $display("fixed_bit_range_rounding test passed");
        end else begin
            $display("fixed_bit_range_rounding test failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("fixed_bit_range_rounding test failed");
        $finish;
    end

endmodule
